/* hdl/lcdnib_pkg.sv */
// Shared types, codes and tables for the character-LCD nibble sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcdnib_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 4;

  localparam logic [KIND_W-1:0] KIND_INIT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMMAND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CURSOR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HOME    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_STROBE_HIGH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STROBE_LOW  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_HOLD = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SETUP  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_UP    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_LONG   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_SHORT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_CMD    = 4'd7;

  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0E;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] ROW1_BASE    = 8'h80;
  localparam logic [7:0] ROW2_BASE    = 8'hC0;
  localparam logic [3:0] WAKE_NIB     = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

  localparam logic [STEP_W-1:0] STEP_POWER_UP  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WAKE_LONG = 4'd1;
  localparam logic [STEP_W-1:0] STEP_WAKE_SHRT = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CLEAR_LO  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_INIT_LAST = 4'd11;
  localparam logic [STEP_W-1:0] STEP_BYTE_HI   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_BYTE_LO   = 4'd1;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
    logic       setup;
    logic       slow;
  } req_t;

  typedef struct packed {
    logic [15:0] data_setup;
    logic [19:0] power_up;
    logic [15:0] wake_long;
    logic [15:0] wake_short;
    logic [15:0] slow_cmd;
  } waits_t;

  function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
    logic [3:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = WAKE_NIB;
      4'd3:             nib = FOUR_BIT_NIB;
      4'd4:             nib = CMD_FUNC_SET[7:4];
      4'd5:             nib = CMD_FUNC_SET[3:0];
      4'd6:             nib = CMD_DISP_ON[7:4];
      4'd7:             nib = CMD_DISP_ON[3:0];
      4'd8:             nib = CMD_CLEAR[7:4];
      4'd9:             nib = CMD_CLEAR[3:0];
      4'd10:            nib = CMD_ENTRY[7:4];
      4'd11:            nib = CMD_ENTRY[3:0];
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage
`default_nettype wire

/* hdl/char_lcd_nibble_sequencer_top.sv */
// Top level of the character-LCD nibble sequencer: configuration registers,
// classifier, descriptor queue and nibble sequencer. Depends on lcdnib_pkg.
`default_nettype none
// A request taken on start appears as a burst of transfers on out_strobe_o,
// one per cycle, once its descriptor has passed the queue and the output
// registers: two transfers for a command, data byte, cursor move, clear or
// home, twelve for init. The sequencer emits one nibble per cycle while the
// queue holds a descriptor, and later requests wait in the queue. Requests
// that yield nothing (other cursor rows, unknown kinds) are taken but leave
// no trace. busy rises only while the QUEUE_DEPTH-entry descriptor queue is
// full. Results cannot be held off; the receiver must take each transfer in
// the cycle it is strobed. The configuration port is always ready.
module char_lcd_nibble_sequencer_top
  import lcdnib_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [7:0]            byte_value_i,
  input  wire logic [1:0]            row_i,
  input  wire logic [7:0]            column_i,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output      logic                  out_strobe_o,
  output      logic                  reg_select_o,
  output      logic [3:0]            nibble_o,
  output      logic [19:0]           wait_before_o,
  output      logic [15:0]           wait_after_o,
  output      logic                  last_o
);

  logic [15:0] strobe_high_q, strobe_low_q, nibble_hold_q, data_setup_q;
  logic [19:0] power_up_q;
  logic [15:0] wake_long_q, wake_short_q, slow_cmd_q;
  logic        cfg_wr;

  req_t   push_req, head;
  logic   push, pop, q_empty, q_full, take;
  waits_t waits;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_high_q <= 16'd300;
      strobe_low_q  <= 16'd250;
      nibble_hold_q <= 16'd2000;
      data_setup_q  <= 16'd40;
      power_up_q    <= 20'd40000;
      wake_long_q   <= 16'd5000;
      wake_short_q  <= 16'd100;
      slow_cmd_q    <= 16'd2000;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_STROBE_HIGH: strobe_high_q <= cfg_data_i[15:0];
        REG_STROBE_LOW:  strobe_low_q  <= cfg_data_i[15:0];
        REG_NIBBLE_HOLD: nibble_hold_q <= cfg_data_i[15:0];
        REG_DATA_SETUP:  data_setup_q  <= cfg_data_i[15:0];
        REG_POWER_UP:    power_up_q    <= cfg_data_i[19:0];
        REG_WAKE_LONG:   wake_long_q   <= cfg_data_i[15:0];
        REG_WAKE_SHORT:  wake_short_q  <= cfg_data_i[15:0];
        REG_SLOW_CMD:    slow_cmd_q    <= cfg_data_i[15:0];
        default:         slow_cmd_q    <= slow_cmd_q;
      endcase
    end
  end

  assign waits.data_setup = data_setup_q;
  assign waits.power_up   = power_up_q;
  assign waits.wake_long  = wake_long_q;
  assign waits.wake_short = wake_short_q;
  assign waits.slow_cmd   = slow_cmd_q
                            | (16'(strobe_high_q & strobe_low_q & nibble_hold_q) & 16'h0);

  assign busy = q_full;
  assign take = start && !busy;

  lcdnib_front u_front (
    .take_i       (take),
    .kind_i       (kind_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .push_o       (push),
    .req_o        (push_req)
  );

  lcdnib_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lcdnib_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .waits_i       (waits),
    .pop_o         (pop),
    .strobe_o      (out_strobe_o),
    .reg_select_o  (reg_select_o),
    .nibble_o      (nibble_o),
    .wait_before_o (wait_before_o),
    .wait_after_o  (wait_after_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

/* hdl/lcdnib_front.sv */
// Request classifier: turns one host request into at most one queue descriptor.
// Depends on lcdnib_pkg.
`default_nettype none
module lcdnib_front
  import lcdnib_pkg::*;
(
  input  wire logic              take_i,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [7:0]        byte_value_i,
  input  wire logic [1:0]        row_i,
  input  wire logic [7:0]        column_i,
  output      logic              push_o,
  output      req_t              req_o
);

  logic [7:0] addr;
  logic       produces;

  assign addr = column_i - 8'd1;

  always_comb begin
    req_o    = '0;
    produces = 1'b1;
    case (kind_i)
      KIND_INIT: begin
        req_o.is_init = 1'b1;
      end
      KIND_COMMAND: begin
        req_o.byte_val = byte_value_i;
      end
      KIND_DATA: begin
        req_o.rs       = 1'b1;
        req_o.setup    = 1'b1;
        req_o.byte_val = byte_value_i;
      end
      KIND_CURSOR: begin
        if (row_i == 2'd1) begin
          req_o.byte_val = addr | ROW1_BASE;
        end else if (row_i == 2'd2) begin
          req_o.byte_val = addr | ROW2_BASE;
        end else begin
          produces = 1'b0;
        end
      end
      KIND_CLEAR: begin
        req_o.byte_val = CMD_CLEAR;
        req_o.slow     = 1'b1;
      end
      KIND_HOME: begin
        req_o.byte_val = CMD_HOME;
        req_o.slow     = 1'b1;
      end
      default: begin
        produces = 1'b0;
      end
    endcase
  end

  assign push_o = take_i && produces;

endmodule
`default_nettype wire

/* hdl/lcdnib_queue.sv */
// Short descriptor queue between the classifier and the nibble sequencer.
// Depends on lcdnib_pkg.
`default_nettype none
module lcdnib_queue
  import lcdnib_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire req_t req_i,
  input  wire logic pop_i,
  output      req_t head_o,
  output      logic empty_o,
  output      logic full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  req_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_FULL);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count out of range");

endmodule
`default_nettype wire

/* hdl/lcdnib_back.sv */
// Nibble sequencer: walks the head descriptor one transfer per cycle.
// Depends on lcdnib_pkg; result ports are registered here.
`default_nettype none
module lcdnib_back
  import lcdnib_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire req_t        head_i,
  input  wire logic        empty_i,
  input  wire waits_t      waits_i,
  output      logic        pop_o,
  output      logic        strobe_o,
  output      logic        reg_select_o,
  output      logic [3:0]  nibble_o,
  output      logic [19:0] wait_before_o,
  output      logic [15:0] wait_after_o,
  output      logic        last_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              strobe_q;
  logic              rs_q, last_q;
  logic [3:0]        nibble_q, nibble_d;
  logic [19:0]       wait_before_q, wait_before_d;
  logic [15:0]       wait_after_q, wait_after_d;
  logic              emit, last_step;

  assign emit      = !empty_i;
  assign last_step = head_i.is_init ? (step_q == STEP_INIT_LAST) : (step_q == STEP_BYTE_LO);
  assign pop_o     = emit && last_step;

  always_comb begin
    step_d = step_q;
    if (emit) begin
      step_d = last_step ? '0 : step_q + 1'b1;
    end
  end

  always_comb begin
    nibble_d      = '0;
    wait_before_d = '0;
    wait_after_d  = '0;
    if (head_i.is_init) begin
      nibble_d = init_nibble(step_q);
      case (step_q)
        STEP_POWER_UP:  wait_before_d = waits_i.power_up;
        STEP_WAKE_LONG: wait_before_d = {4'h0, waits_i.wake_long};
        STEP_WAKE_SHRT: wait_before_d = {4'h0, waits_i.wake_short};
        STEP_CLEAR_LO:  wait_after_d  = waits_i.slow_cmd;
        default:        wait_before_d = '0;
      endcase
    end else if (step_q == STEP_BYTE_HI) begin
      nibble_d = head_i.byte_val[7:4];
      if (head_i.setup) begin
        wait_before_d = {4'h0, waits_i.data_setup};
      end
    end else begin
      nibble_d = head_i.byte_val[3:0];
      if (head_i.slow) begin
        wait_after_d = waits_i.slow_cmd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q          <= head_i.rs;
    last_q        <= last_step;
    nibble_q      <= nibble_d;
    wait_before_q <= wait_before_d;
    wait_after_q  <= wait_after_d;
  end

  assign strobe_o      = strobe_q;
  assign reg_select_o  = rs_q;
  assign nibble_o      = nibble_q;
  assign wait_before_o = wait_before_q;
  assign wait_after_o  = wait_after_q;
  assign last_o        = last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_INIT_LAST)
    else $error("step beyond init sequence");

  a_byte_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !head_i.is_init) |-> (step_q <= STEP_BYTE_LO))
    else $error("byte request past its low nibble");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> (step_q == '0))
    else $error("sequencer step not rewound after last transfer");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |=> $stable(step_q))
    else $error("step advanced with no request");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for char_lcd_nibble_sequencer_top: directed and random LCD requests, register
// writes between phases, and every strobed nibble transfer scoreboarded against a local model.
// Depends on lcdnib_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module tb_top;
  import lcdnib_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned RANDOM_ITEMS = 140;
  localparam int unsigned PHASES       = 4;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam logic [1:0] ROW_ONE      = 2'd1;
  localparam logic [1:0] ROW_TWO      = 2'd2;
  localparam logic [1:0] ROW_OFF_LOW  = 2'd0;
  localparam logic [1:0] ROW_OFF_HIGH = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 4'd15;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [19:0] before_ticks;
    logic [15:0] after_ticks;
    logic        last;
  } lcd_xfer_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     kind_i;
  logic [7:0]            byte_value_i;
  logic [1:0]            row_i;
  logic [7:0]            column_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  out_strobe_o;
  logic                  reg_select_o;
  logic [3:0]            nibble_o;
  logic [19:0]           wait_before_o;
  logic [15:0]           wait_after_o;
  logic                  last_o;

  lcd_xfer_t transfers_due[$];
  lcd_xfer_t seen_due;
  waits_t    wait_cfg;
  bit        back_to_back;
  int unsigned mismatches;
  int unsigned requests_taken;
  int unsigned transfers_checked;
  int unsigned register_writes;
  int unsigned cycle_count;

  char_lcd_nibble_sequencer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .byte_value_i  (byte_value_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_strobe_o  (out_strobe_o),
    .reg_select_o  (reg_select_o),
    .nibble_o      (nibble_o),
    .wait_before_o (wait_before_o),
    .wait_after_o  (wait_after_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_lcd_nibble_sequencer_top regression: fail");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [19:0] want,
                               input logic [19:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      if (transfers_due.size() == 0) begin
        note_mismatch("unexpected transfer (nibble shown)", 20'h0, {16'h0, nibble_o});
      end else begin
        seen_due = transfers_due.pop_front();
        transfers_checked++;
        if (reg_select_o !== seen_due.rs)
          note_mismatch("reg_select", 20'(seen_due.rs), 20'(reg_select_o));
        if (nibble_o !== seen_due.nib)
          note_mismatch("nibble", 20'(seen_due.nib), 20'(nibble_o));
        if (wait_before_o !== seen_due.before_ticks)
          note_mismatch("wait_before", seen_due.before_ticks, wait_before_o);
        if (wait_after_o !== seen_due.after_ticks)
          note_mismatch("wait_after", 20'(seen_due.after_ticks), 20'(wait_after_o));
        if (last_o !== seen_due.last)
          note_mismatch("last", 20'(seen_due.last), 20'(last_o));
      end
    end
  end

  task automatic due_nibble(input logic rs, input logic [3:0] nib,
                            input logic [19:0] before_ticks, input logic [15:0] after_ticks);
    lcd_xfer_t x;
    x.rs           = rs;
    x.nib          = nib;
    x.before_ticks = before_ticks;
    x.after_ticks  = after_ticks;
    x.last         = 1'b0;
    transfers_due.push_back(x);
  endtask

  task automatic due_byte(input logic rs, input logic [7:0] b,
                          input logic [19:0] before_ticks, input logic [15:0] after_ticks);
    due_nibble(rs, b[7:4], before_ticks, 16'h0);
    due_nibble(rs, b[3:0], 20'h0, after_ticks);
  endtask

  task automatic predict_transfers(input logic [KIND_W-1:0] kind, input logic [7:0] b,
                                   input logic [1:0] row, input logic [7:0] col);
    int unsigned first;
    logic [7:0] addr;
    lcd_xfer_t tail;
    first = transfers_due.size();
    addr  = col - 8'd1;
    case (kind)
      KIND_INIT: begin
        due_nibble(1'b0, WAKE_NIB, wait_cfg.power_up, 16'h0);
        due_nibble(1'b0, WAKE_NIB, {4'h0, wait_cfg.wake_long}, 16'h0);
        due_nibble(1'b0, WAKE_NIB, {4'h0, wait_cfg.wake_short}, 16'h0);
        due_nibble(1'b0, FOUR_BIT_NIB, 20'h0, 16'h0);
        due_byte(1'b0, CMD_FUNC_SET, 20'h0, 16'h0);
        due_byte(1'b0, CMD_DISP_ON, 20'h0, 16'h0);
        due_byte(1'b0, CMD_CLEAR, 20'h0, wait_cfg.slow_cmd);
        due_byte(1'b0, CMD_ENTRY, 20'h0, 16'h0);
      end
      KIND_COMMAND: due_byte(1'b0, b, 20'h0, 16'h0);
      KIND_DATA:    due_byte(1'b1, b, {4'h0, wait_cfg.data_setup}, 16'h0);
      KIND_CURSOR: begin
        if (row == ROW_ONE)
          due_byte(1'b0, addr | ROW1_BASE, 20'h0, 16'h0);
        else if (row == ROW_TWO)
          due_byte(1'b0, addr | ROW2_BASE, 20'h0, 16'h0);
      end
      KIND_CLEAR: due_byte(1'b0, CMD_CLEAR, 20'h0, wait_cfg.slow_cmd);
      KIND_HOME:  due_byte(1'b0, CMD_HOME, 20'h0, wait_cfg.slow_cmd);
      default: ;
    endcase
    if (transfers_due.size() > first) begin
      tail = transfers_due.pop_back();
      tail.last = 1'b1;
      transfers_due.push_back(tail);
    end
  endtask

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [7:0] b,
                              input logic [1:0] row, input logic [7:0] col);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    kind_i       <= kind;
    byte_value_i <= b;
    row_i        <= row;
    column_i     <= col;
    do @(posedge clk_i); while (busy);
    requests_taken++;
    predict_transfers(kind, b, row, col);
  endtask

  // drop start, drain every due transfer, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (transfers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    repeat ($urandom_range(0, 8)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    register_writes++;
    case (idx)
      REG_DATA_SETUP: wait_cfg.data_setup = data[15:0];
      REG_POWER_UP:   wait_cfg.power_up   = data[19:0];
      REG_WAKE_LONG:  wait_cfg.wake_long  = data[15:0];
      REG_WAKE_SHORT: wait_cfg.wake_short = data[15:0];
      REG_SLOW_CMD:   wait_cfg.slow_cmd   = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_register_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_all_registers(input bit pick_random, input logic [CFG_DATA_W-1:0] data);
    for (int i = REG_STROBE_HIGH; i <= REG_SLOW_CMD; i++)
      write_register(i[CFG_IDX_W-1:0], pick_random ? pick_register_value() : data);
  endtask

  task automatic test_power_on_defaults();
    send_request(KIND_INIT, 8'h00, ROW_ONE, 8'h01);
    send_request(KIND_COMMAND, 8'h00, ROW_ONE, 8'h01);
    send_request(KIND_DATA, 8'hFF, ROW_TWO, 8'hFF);
    send_request(KIND_CLEAR, 8'h00, ROW_OFF_LOW, 8'h00);
    send_request(KIND_HOME, 8'hFF, ROW_OFF_HIGH, 8'hFF);
    wait_idle();
  endtask

  task automatic test_request_kinds();
    send_request(KIND_COMMAND, 8'hFF, ROW_OFF_LOW, 8'h00);
    send_request(KIND_COMMAND, 8'hA5, ROW_TWO, 8'h5A);
    send_request(KIND_DATA, 8'h00, ROW_OFF_HIGH, 8'hFF);
    send_request(KIND_DATA, 8'h5A, ROW_ONE, 8'hA5);
    send_request(KIND_CURSOR, 8'h00, ROW_ONE, 8'h01);
    send_request(KIND_CURSOR, 8'hFF, ROW_TWO, 8'hFF);
    send_request(KIND_CURSOR, 8'h00, ROW_ONE, 8'h00);
    send_request(KIND_CURSOR, 8'h00, ROW_TWO, 8'h00);
    send_request(KIND_CURSOR, 8'h00, ROW_ONE, 8'h80);
    send_request(KIND_CURSOR, 8'hFF, ROW_OFF_LOW, 8'h10);
    send_request(KIND_CURSOR, 8'hFF, ROW_OFF_HIGH, 8'h10);
    send_request(KIND_SPARE_A, 8'hFF, ROW_OFF_HIGH, 8'hFF);
    send_request(KIND_SPARE_B, 8'h00, ROW_OFF_LOW, 8'h00);
    send_request(KIND_CLEAR, 8'hFF, ROW_TWO, 8'h00);
    send_request(KIND_HOME, 8'h00, ROW_ONE, 8'hFF);
    send_request(KIND_INIT, 8'hFF, ROW_OFF_HIGH, 8'hFF);
    wait_idle();
  endtask

  task automatic run_wait_sequences();
    send_request(KIND_INIT, 8'h3C, ROW_ONE, 8'h01);
    send_request(KIND_DATA, 8'hC3, ROW_ONE, 8'h01);
    send_request(KIND_CLEAR, 8'h00, ROW_ONE, 8'h01);
    send_request(KIND_HOME, 8'h00, ROW_ONE, 8'h01);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_all_registers(1'b0, '1);
    write_register(REG_PAST_END, '0);
    write_register(REG_TOP_IDX, 32'h0000_1234);
    run_wait_sequences();
    write_all_registers(1'b0, '0);
    write_register(REG_PAST_END, '1);
    run_wait_sequences();
  endtask

  task automatic test_random_traffic();
    int unsigned produced;
    int unsigned quota;
    int unsigned pick;
    logic [KIND_W-1:0] kind;
    logic [1:0] row;
    produced = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_all_registers(1'b1, '0);
      if ($urandom_range(0, 1))
        write_register(CFG_IDX_W'($urandom_range(REG_PAST_END, REG_TOP_IDX)), $urandom);
      quota = (p + 1) * RANDOM_ITEMS / PHASES;
      while (produced < quota) begin
        if (produced % 10 == 0)
          back_to_back = ($urandom_range(0, 3) == 0);
        // hold off until the display pipeline is empty, once per phase
        if (produced == quota - (RANDOM_ITEMS / PHASES) / 2) begin
          wait_idle();
          produced++;
          continue;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6)       kind = KIND_INIT;
        else if (pick < 30) kind = KIND_COMMAND;
        else if (pick < 55) kind = KIND_DATA;
        else if (pick < 75) kind = KIND_CURSOR;
        else if (pick < 85) kind = KIND_CLEAR;
        else if (pick < 95) kind = KIND_HOME;
        else                kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        pick = $urandom_range(0, 9);
        if (pick == 0)      row = ROW_OFF_LOW;
        else if (pick == 1) row = ROW_OFF_HIGH;
        else                row = pick[0] ? ROW_ONE : ROW_TWO;
        send_request(kind, 8'($urandom), row, 8'($urandom));
        if (kind <= KIND_HOME && !(kind == KIND_CURSOR && row != ROW_ONE && row != ROW_TWO))
          produced++;
      end
      back_to_back = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = KIND_INIT;
    byte_value_i = 8'h00;
    row_i        = ROW_OFF_LOW;
    column_i     = 8'h00;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_STROBE_HIGH;
    cfg_data_i   = '0;
    back_to_back = 1'b0;
    wait_cfg.data_setup = 16'd40;
    wait_cfg.power_up   = 20'd40000;
    wait_cfg.wake_long  = 16'd5000;
    wait_cfg.wake_short = 16'd100;
    wait_cfg.slow_cmd   = 16'd2000;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_on_defaults();
    test_request_kinds();
    test_register_extremes();
    test_random_traffic();
    wait_idle();

    if (transfers_due.size() != 0) begin
      $display("%0d transfers never arrived", transfers_due.size());
      mismatches += transfers_due.size();
    end
    $display("Covered %0d requests and %0d checked transfers across %0d register writes,",
             requests_taken, transfers_checked, register_writes);
    $display("including init, cursor wrap, ignored rows and kinds, and register extremes.");
    if (mismatches == 0) begin
      $display("char_lcd_nibble_sequencer_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("char_lcd_nibble_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule
